### design/rc3s_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc3s_pkg
// Shared types and constants of the rgba 3x3 convolution stream unit.
// ----------------------------------------------------------------------------
package rc3s_pkg;

    // pixel and channel layout
    localparam int CH_W     = 8;
    localparam int NUM_CH   = 4;
    localparam int PIX_W    = CH_W * NUM_CH;
    localparam int NUM_TAPS = 9;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 36;
    localparam int SIZE_W     = 11;

    // weights: signed q4.8
    localparam int COEF_W         = 12;
    localparam int COEF_FRAC_BITS = 8;

    // accumulator widths: product, column sum of three, total of nine
    localparam int PROD_W   = COEF_W + CH_W + 1;
    localparam int COLSUM_W = PROD_W + 2;
    localparam int SUM_W    = COLSUM_W + 2;

    // weight register reset values
    localparam logic [CFG_DATA_W-1:0] COEF_LEFT_RST   = 36'd0;
    localparam logic [CFG_DATA_W-1:0] COEF_MIDDLE_RST = 36'd16777216;
    localparam logic [CFG_DATA_W-1:0] COEF_RIGHT_RST  = 36'd0;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_COEF_LEFT    = 3'd2,
        CFG_COEF_MIDDLE  = 3'd3,
        CFG_COEF_RIGHT   = 3'd4
    } t_cfg_idx;

    // one channel byte per window tap, column-major
    typedef logic [CH_W-1:0] t_tap_arr [NUM_TAPS];

    // one weight per window tap, column-major
    typedef logic signed [COEF_W-1:0] t_coef_arr [NUM_TAPS];

    // load strobes of the lane pipeline
    typedef struct packed {
        logic ld_prod;
        logic ld_col;
        logic ld_out;
    } t_lane_en;

endpackage

### design/rgba_conv3x3_stream_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba_conv3x3_stream_unit
// Streaming 3x3 convolution of rgba pixels with zero padding at the edges.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall with i_op and the four channel bytes.
// Pixels of a frame come in raster order (i_op = 0), then image_width + 1
// flush requests (i_op = 1). A request of the wrong kind is taken and dropped.
// Output channel: o_out_valid / i_out_stall; o_frame_last marks the last pixel.
// Output pixel i belongs to the request that brings input i + W + 1 and shows
// on o_out_valid after the stage 1, product, column sum and output registers.
// Throughput is one request per cycle while o_in_stall is low; four channel
// lanes run in parallel, each a three-stage multiply / add / clamp pipeline.
// Configuration: i_cfg_valid / o_cfg_ready (always ready), index and data;
// write only while the unit is idle. Writing width or height restarts the
// frame. Sizes of zero act as one, sizes above the maximum act as maximum.
// Reset restores the default registers and an empty pipeline; line memory
// contents are not cleared (unused until written rows come into view).
// When the receiver stalls, the result holds and the pipeline keeps taking
// requests until every stage is full, then o_in_stall rises.
// ----------------------------------------------------------------------------
module rgba_conv3x3_stream_unit
    import rc3s_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_op,
    input  logic [CH_W-1:0]       i_red_in,
    input  logic [CH_W-1:0]       i_green_in,
    input  logic [CH_W-1:0]       i_blue_in,
    input  logic [CH_W-1:0]       i_alpha_in,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CH_W-1:0]       o_red_out,
    output logic [CH_W-1:0]       o_green_out,
    output logic [CH_W-1:0]       o_blue_out,
    output logic [CH_W-1:0]       o_alpha_out,
    output logic                  o_frame_last,
    // configuration channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int OYB   = $clog2(MAX_HEIGHT);
    localparam int HB    = $clog2(MAX_HEIGHT + 1);
    localparam int RB    = $clog2(MAX_HEIGHT + 3);
    localparam int W_RST = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
    localparam int H_RST = (1024 > MAX_HEIGHT) ? MAX_HEIGHT : 1024;

    // configuration registers
    logic [WB-1:0]         r_w;
    logic [HB-1:0]         r_h;
    logic [CFG_DATA_W-1:0] r_coef [3];

    // frame position counters
    logic [COL_W-1:0] r_col;
    logic [RB-1:0]    r_row;
    logic [COL_W-1:0] r_ox;
    logic [OYB-1:0]   r_oy;

    // pipeline control
    logic en1, en2, en3, en4;
    logic r_v1, r_v2, r_v3, r_ov;
    logic r_out1, r_last1, r_last2, r_last3, r_last_o;

    // stage 1 payload
    logic [PIX_W-1:0]    r_pix1;
    logic [NUM_TAPS-1:0] r_mask1;

    // window of three columns, column-major
    logic [PIX_W-1:0] r_win [NUM_TAPS];
    logic [PIX_W-1:0] n_win [NUM_TAPS];

    // stage 0 decode
    logic                acc, active, flushing, emit, last;
    logic                col_wrap, ox_wrap, oy_last;
    logic [PIX_W-1:0]    pix;
    logic [NUM_TAPS-1:0] mask;
    logic [2:0]          col_ok, row_ok;
    logic [PIX_W-1:0]    lb_top, lb_mid;
    logic                cfg_we;
    logic [SIZE_W-1:0]   cfg_size;

    t_lane_en          lane_en;
    t_coef_arr         coef;
    logic [CH_W-1:0]   lane_val [NUM_CH];

    // ready chain from the output register back to the input
    assign en4        = !r_ov || !i_out_stall;
    assign en3        = !r_v3 || en4;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign o_in_stall = !en1;
    assign acc        = i_in_valid && en1;

    // decode of the current position
    always_comb begin
        flushing = r_row >= RB'(r_h);
        active   = acc && (i_op == flushing);
        pix      = flushing ? '0 : {i_alpha_in, i_blue_in, i_green_in, i_red_in};
        col_wrap = (WB'(r_col) + WB'(1)) == r_w;
        emit     = (r_row >= RB'(2)) || ((r_row == RB'(1)) && (r_col != '0));
        ox_wrap  = (WB'(r_ox) + WB'(1)) == r_w;
        oy_last  = (HB'(r_oy) + HB'(1)) == r_h;
        last     = ox_wrap && oy_last;
        col_ok   = {!ox_wrap, 1'b1, r_ox != '0};
        row_ok   = {!oy_last, 1'b1, r_oy != '0};
        for (int kx = 0; kx < 3; kx++) begin
            for (int ky = 0; ky < 3; ky++) begin
                mask[kx*3+ky] = col_ok[kx] && row_ok[ky];
            end
        end
    end

    // configuration writes
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign cfg_size    = i_cfg_data[SIZE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w       <= WB'(W_RST);
            r_h       <= HB'(H_RST);
            r_coef[0] <= COEF_LEFT_RST;
            r_coef[1] <= COEF_MIDDLE_RST;
            r_coef[2] <= COEF_RIGHT_RST;
        end else if (cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_WIDTH: begin
                    if (cfg_size == '0) begin
                        r_w <= WB'(1);
                    end else if (32'(cfg_size) > 32'(MAX_WIDTH)) begin
                        r_w <= WB'(MAX_WIDTH);
                    end else begin
                        r_w <= WB'(cfg_size);
                    end
                end
                CFG_IMAGE_HEIGHT: begin
                    if (cfg_size == '0) begin
                        r_h <= HB'(1);
                    end else if (32'(cfg_size) > 32'(MAX_HEIGHT)) begin
                        r_h <= HB'(MAX_HEIGHT);
                    end else begin
                        r_h <= HB'(cfg_size);
                    end
                end
                CFG_COEF_LEFT:   r_coef[0] <= i_cfg_data;
                CFG_COEF_MIDDLE: r_coef[1] <= i_cfg_data;
                CFG_COEF_RIGHT:  r_coef[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input and output position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_ox  <= '0;
            r_oy  <= '0;
        end else if (cfg_we && (t_cfg_idx'(i_cfg_index) == CFG_IMAGE_WIDTH ||
                                t_cfg_idx'(i_cfg_index) == CFG_IMAGE_HEIGHT)) begin
            r_col <= '0;
            r_row <= '0;
            r_ox  <= '0;
            r_oy  <= '0;
        end else if (active) begin
            if (emit && last) begin
                r_col <= '0;
                r_row <= '0;
                r_ox  <= '0;
                r_oy  <= '0;
            end else begin
                if (col_wrap) begin
                    r_col <= '0;
                    r_row <= r_row + RB'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
                if (emit) begin
                    if (ox_wrap) begin
                        r_ox <= '0;
                        r_oy <= r_oy + OYB'(1);
                    end else begin
                        r_ox <= r_ox + COL_W'(1);
                    end
                end
            end
        end
    end

    // line memories for the two rows above
    rc3s_linebuf #(
        .DEPTH (MAX_WIDTH)
    ) u_linebuf (
        .i_clk   (i_clk),
        .i_en    (active),
        .i_addr  (r_col),
        .i_sel   (r_row[0]),
        .i_wdata (pix),
        .o_top   (lb_top),
        .o_mid   (lb_mid)
    );

    // window shift: new right column from the line memories and the pixel
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            n_win[i] = r_win[i+3];
        end
        n_win[6] = lb_top;
        n_win[7] = lb_mid;
        n_win[8] = r_pix1;
    end

    // pipeline valid and control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
            for (int i = 0; i < NUM_TAPS; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (en1) begin
                r_v1 <= active;
            end
            if (en2) begin
                r_v2 <= r_v1 && r_out1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_ov <= r_v3;
            end
            if (r_v1 && en2) begin
                r_win <= n_win;
            end
        end
    end

    // payload carried along the pipeline
    always_ff @(posedge i_clk) begin
        if (active) begin
            r_pix1  <= pix;
            r_mask1 <= mask;
            r_out1  <= emit;
            r_last1 <= last;
        end
        if (lane_en.ld_prod) begin
            r_last2 <= r_last1;
        end
        if (lane_en.ld_col) begin
            r_last3 <= r_last2;
        end
        if (lane_en.ld_out) begin
            r_last_o <= r_last3;
        end
    end

    // lane load strobes
    assign lane_en.ld_prod = r_v1 && r_out1 && en2;
    assign lane_en.ld_col  = r_v2 && en3;
    assign lane_en.ld_out  = r_v3 && en4;

    // weights unpacked per tap: register kx, field ky
    always_comb begin
        for (int kx = 0; kx < 3; kx++) begin
            for (int ky = 0; ky < 3; ky++) begin
                coef[kx*3+ky] = $signed(r_coef[kx][COEF_W*ky +: COEF_W]);
            end
        end
    end

    // one lane per color channel
    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
        t_tap_arr tap;

        always_comb begin
            for (int i = 0; i < NUM_TAPS; i++) begin
                tap[i] = n_win[i][CH_W*ch +: CH_W];
            end
        end

        rc3s_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (lane_en),
            .i_tap   (tap),
            .i_mask  (r_mask1),
            .i_coef  (coef),
            .o_value (lane_val[ch])
        );
    end

    // merge lanes into the output pixel
    assign o_out_valid  = r_ov;
    assign o_red_out    = lane_val[0];
    assign o_green_out  = lane_val[1];
    assign o_blue_out   = lane_val[2];
    assign o_alpha_out  = lane_val[3];
    assign o_frame_last = r_last_o;

endmodule

### design/rc3s_linebuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc3s_linebuf
// Two line memories indexed by column. The line of even rows goes to one,
// odd rows to the other; both are read at the same column with registered
// read data (old contents) so the two previous lines come out together.
// ----------------------------------------------------------------------------
module rc3s_linebuf
    import rc3s_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic                     i_sel,
    input  logic [PIX_W-1:0]         i_wdata,
    output logic [PIX_W-1:0]         o_top,
    output logic [PIX_W-1:0]         o_mid
);

    logic [PIX_W-1:0] mem_even [DEPTH];
    logic [PIX_W-1:0] mem_odd  [DEPTH];
    logic [PIX_W-1:0] r_rd_even;
    logic [PIX_W-1:0] r_rd_odd;
    logic             r_sel;

    // read first, then write the current line's memory
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd_even <= mem_even[i_addr];
            r_rd_odd  <= mem_odd[i_addr];
            r_sel     <= i_sel;
            if (i_sel) begin
                mem_odd[i_addr] <= i_wdata;
            end else begin
                mem_even[i_addr] <= i_wdata;
            end
        end
    end

    // same-parity memory holds the line two rows up, the other one row up
    assign o_top = r_sel ? r_rd_odd  : r_rd_even;
    assign o_mid = r_sel ? r_rd_even : r_rd_odd;

endmodule

### design/rc3s_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc3s_lane
// One color channel: nine weighted taps, column sums, total, then floor
// and clamp to 0..255. Three register stages.
// ----------------------------------------------------------------------------
module rc3s_lane
    import rc3s_pkg::*;
(
    input  logic                i_clk,
    input  t_lane_en            i_en,
    input  t_tap_arr            i_tap,
    input  logic [NUM_TAPS-1:0] i_mask,
    input  t_coef_arr           i_coef,
    output logic [CH_W-1:0]     o_value
);

    localparam int SHIFT_W = SUM_W - COEF_FRAC_BITS;

    logic signed [PROD_W-1:0]   n_prod   [NUM_TAPS];
    logic signed [PROD_W-1:0]   r_prod   [NUM_TAPS];
    logic signed [COLSUM_W-1:0] n_colsum [3];
    logic signed [COLSUM_W-1:0] r_colsum [3];
    logic signed [SUM_W-1:0]    total;
    logic [SHIFT_W-1:0]         shifted;
    logic [CH_W-1:0]            n_value;
    logic [CH_W-1:0]            r_value;

    // products, taps outside the frame forced to zero
    always_comb begin
        for (int i = 0; i < NUM_TAPS; i++) begin
            n_prod[i] = i_coef[i] * $signed({1'b0, (i_mask[i] ? i_tap[i] : {CH_W{1'b0}})});
        end
    end

    // one sum per window column
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_colsum[k] = COLSUM_W'(r_prod[3*k]) + COLSUM_W'(r_prod[3*k+1])
                        + COLSUM_W'(r_prod[3*k+2]);
        end
    end

    // total, floor to integer, clamp
    always_comb begin
        total   = SUM_W'(r_colsum[0]) + SUM_W'(r_colsum[1]) + SUM_W'(r_colsum[2]);
        shifted = total[SUM_W-1:COEF_FRAC_BITS];
        if (total <= 0) begin
            n_value = '0;
        end else if (shifted > SHIFT_W'(255)) begin
            n_value = {CH_W{1'b1}};
        end else begin
            n_value = shifted[CH_W-1:0];
        end
    end

    // pipeline registers
    always_ff @(posedge i_clk) begin
        if (i_en.ld_prod) begin
            r_prod <= n_prod;
        end
        if (i_en.ld_col) begin
            r_colsum <= n_colsum;
        end
        if (i_en.ld_out) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rgba 3x3 convolution stream unit.
// ----------------------------------------------------------------------------
// Streams frames of random rgba pixels, most followed by their flush requests,
// through the unit under several frame sizes and weight sets. The bench
// carries its own line stores and tap window, and predicts every filtered
// pixel when its request is taken. Each filtered pixel that leaves the unit
// is checked field by field against the oldest prediction.
// Both sides idle and stall at random in rotating phases. The stimulus also
// covers wrong-kind requests, zero and oversized frame dimensions, weight
// changes and frame restarts part-way through a frame, and one long stall
// of the output side that fills the pipeline.
// ----------------------------------------------------------------------------
module tb;
    import rc3s_pkg::*;

    localparam int MAX_W          = 1024;
    localparam int MAX_H          = 1024;
    localparam int RESET_CYCLES   = 12;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 600;
    localparam int HOLD_OFF       = 80;
    localparam int REPORT_LIMIT   = 10;

    // an index outside the register map, writes to it change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = '1;

    // idling phases of the two channels
    typedef enum int {
        PACE_FULL,
        PACE_SEND_GAPS,
        PACE_RECV_STALLS,
        PACE_BOTH
    } t_pace;

    // one filtered output pixel
    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
        logic            last;
    } t_rgba_out;

    // ------------------------------------------------------------------------
    // filter prediction and checking of filtered pixels
    // ------------------------------------------------------------------------
    class conv_scoreboard;
        logic [SIZE_W-1:0]     width_reg;
        logic [SIZE_W-1:0]     height_reg;
        logic [CFG_DATA_W-1:0] coef_reg [3];
        logic [PIX_W-1:0]      upper_line [MAX_W];
        logic [PIX_W-1:0]      lower_line [MAX_W];
        logic [PIX_W-1:0]      window [NUM_TAPS];
        int unsigned           in_col;
        int unsigned           in_row;
        int unsigned           out_idx;
        t_rgba_out             filtered_q [$];
        int unsigned           err_count;

        function new();
            width_reg   = SIZE_W'(MAX_W);
            height_reg  = SIZE_W'(MAX_H);
            coef_reg[0] = COEF_LEFT_RST;
            coef_reg[1] = COEF_MIDDLE_RST;
            coef_reg[2] = COEF_RIGHT_RST;
            foreach (upper_line[i]) begin
                upper_line[i] = '0;
                lower_line[i] = '0;
            end
            foreach (window[i]) window[i] = '0;
            restart();
            err_count = 0;
        endfunction

        function void restart();
            in_col  = 0;
            in_row  = 0;
            out_idx = 0;
        endfunction

        // zero acts as one, oversize acts as the maximum
        function int eff_dim(logic [SIZE_W-1:0] v, int lim);
            if (v == 0) return 1;
            if (int'(v) > lim) return lim;
            return int'(v);
        endfunction

        function int frame_w();
            return eff_dim(width_reg, MAX_W);
        endfunction

        function int frame_h();
            return eff_dim(height_reg, MAX_H);
        endfunction

        function int pending();
            return filtered_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_IMAGE_WIDTH: begin
                    width_reg = data[SIZE_W-1:0];
                    restart();
                end
                CFG_IMAGE_HEIGHT: begin
                    height_reg = data[SIZE_W-1:0];
                    restart();
                end
                CFG_COEF_LEFT:   coef_reg[0] = data;
                CFG_COEF_MIDDLE: coef_reg[1] = data;
                CFG_COEF_RIGHT:  coef_reg[2] = data;
                default: ;
            endcase
        endfunction

        // weighted sum of the window per channel, taps outside the frame dropped
        function t_rgba_out convolve(int w, int h);
            t_rgba_out       res;
            logic [CH_W-1:0] chan [NUM_CH];
            int              ox, oy, sx, sy, sum, cv, pv;
            ox = int'(out_idx % w);
            oy = int'(out_idx / w);
            for (int ch = 0; ch < NUM_CH; ch++) begin
                sum = 0;
                for (int kx = 0; kx < 3; kx++) begin
                    sx = ox + kx - 1;
                    if (sx < 0 || sx >= w) continue;
                    for (int ky = 0; ky < 3; ky++) begin
                        sy = oy + ky - 1;
                        if (sy < 0 || sy >= h) continue;
                        cv = $signed(coef_reg[kx][ky*COEF_W +: COEF_W]);
                        pv = int'(window[kx*3 + ky][ch*CH_W +: CH_W]);
                        sum += cv * pv;
                    end
                end
                if (sum <= 0)
                    chan[ch] = '0;
                else if ((sum >>> COEF_FRAC_BITS) > 255)
                    chan[ch] = '1;
                else
                    chan[ch] = CH_W'(sum >>> COEF_FRAC_BITS);
            end
            res.red   = chan[0];
            res.green = chan[1];
            res.blue  = chan[2];
            res.alpha = chan[3];
            res.last  = (out_idx == w * h - 1);
            out_idx++;
            if (res.last) restart();
            return res;
        endfunction

        // one accepted request: advance the line stores and window
        function void take_request(logic op, logic [PIX_W-1:0] pix_in);
            int               w, h, p;
            logic             flushing;
            logic [PIX_W-1:0] pix, top, mid;
            w = frame_w();
            h = frame_h();
            p = int'(in_row) * w + int'(in_col);
            flushing = (p >= w * h);
            // wrong-kind requests are dropped
            if (flushing != op) return;
            pix = flushing ? '0 : pix_in;
            top = upper_line[in_col];
            mid = lower_line[in_col];
            upper_line[in_col] = mid;
            lower_line[in_col] = pix;
            for (int i = 0; i < 6; i++) window[i] = window[i + 3];
            window[6] = top;
            window[7] = mid;
            window[8] = pix;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
            if (p >= w + 1) filtered_q.push_back(convolve(w, h));
        endfunction

        function void check_pixel(t_rgba_out got);
            t_rgba_out want;
            if (filtered_q.size() == 0) begin
                err_count++;
                if (err_count <= REPORT_LIMIT)
                    $display("unexpected pixel: r=%0d g=%0d b=%0d a=%0d last=%0d",
                             got.red, got.green, got.blue, got.alpha, got.last);
                return;
            end
            want = filtered_q.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.alpha !== want.alpha ||
                got.last !== want.last) begin
                err_count++;
                if (err_count <= REPORT_LIMIT)
                    $display("pixel mismatch: expected r=%0d g=%0d b=%0d a=%0d last=%0d",
                             want.red, want.green, want.blue, want.alpha, want.last,
                             ", got r=%0d g=%0d b=%0d a=%0d last=%0d",
                             got.red, got.green, got.blue, got.alpha, got.last);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals and unit
    // ------------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic                  i_op        = 1'b0;
    logic [CH_W-1:0]       i_red_in    = '0;
    logic [CH_W-1:0]       i_green_in  = '0;
    logic [CH_W-1:0]       i_blue_in   = '0;
    logic [CH_W-1:0]       i_alpha_in  = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [CH_W-1:0]       o_red_out;
    logic [CH_W-1:0]       o_green_out;
    logic [CH_W-1:0]       o_blue_out;
    logic [CH_W-1:0]       o_alpha_out;
    logic                  o_frame_last;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    conv_scoreboard sb;
    t_pace          pace              = PACE_FULL;
    int             stall_hold_cycles = 0;
    int             items_sent        = 0;

    rgba_conv3x3_stream_unit #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_op         (i_op),
        .i_red_in     (i_red_in),
        .i_green_in   (i_green_in),
        .i_blue_in    (i_blue_in),
        .i_alpha_in   (i_alpha_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_alpha_out  (o_alpha_out),
        .o_frame_last (o_frame_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // 10 ns clock
    initial begin : clock_gen
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------------
    function automatic logic [PIX_W-1:0] rand_pixel();
        logic [PIX_W-1:0] px;
        px = PIX_W'($urandom);
        // push some channels to the ends of their range
        for (int c = 0; c < NUM_CH; c++) begin
            case ($urandom_range(7))
                0: px[c*CH_W +: CH_W] = '0;
                1: px[c*CH_W +: CH_W] = '1;
                default: ;
            endcase
        end
        return px;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_coef_reg();
        logic [CFG_DATA_W-1:0] r;
        r = '0;
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(5))
                0: r[k*COEF_W +: COEF_W] = 12'h800;
                1: r[k*COEF_W +: COEF_W] = 12'h7FF;
                2: r[k*COEF_W +: COEF_W] = 12'h100;
                3: r[k*COEF_W +: COEF_W] = COEF_W'($urandom_range(128) - 64);
                default: r[k*COEF_W +: COEF_W] = COEF_W'($urandom);
            endcase
        end
        return r;
    endfunction

    // mostly small frame dimensions, sometimes zero or one
    function automatic int rand_dim(int top);
        case ($urandom_range(9))
            0: return 0;
            1: return 1;
            default: return $urandom_range(top, 2);
        endcase
    endfunction

    function automatic logic sender_gap();
        case (pace)
            PACE_SEND_GAPS: return $urandom_range(99) < 51;
            PACE_BOTH:      return $urandom_range(99) < 13;
            default:        return 1'b0;
        endcase
    endfunction

    function automatic logic receiver_stall();
        case (pace)
            PACE_RECV_STALLS: return $urandom_range(99) < 51;
            PACE_BOTH:        return $urandom_range(99) < 13;
            default:          return 1'b0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // size write with junk in the unused upper data bits
    task automatic write_size(input logic [CFG_IDX_W-1:0] idx, input int dim);
        logic [CFG_DATA_W-1:0] d;
        d = CFG_DATA_W'({$urandom, $urandom});
        d[SIZE_W-1:0] = SIZE_W'(dim);
        write_reg(idx, d);
    endtask

    task automatic write_all_coefs(input logic [CFG_DATA_W-1:0] d);
        write_reg(CFG_COEF_LEFT, d);
        write_reg(CFG_COEF_MIDDLE, d);
        write_reg(CFG_COEF_RIGHT, d);
    endtask

    task automatic push_request(input logic op, input logic [PIX_W-1:0] px);
        @(negedge i_clk);
        while (sender_gap()) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        {i_alpha_in, i_blue_in, i_green_in, i_red_in} <= px;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_pixels(input int n, input int noise_pct);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < noise_pct) push_request(1'b1, rand_pixel());
            push_request(1'b0, rand_pixel());
            items_sent++;
        end
    endtask

    task automatic send_flushes(input int n, input int noise_pct);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < noise_pct) push_request(1'b0, rand_pixel());
            push_request(1'b1, rand_pixel());
            items_sent++;
        end
    endtask

    task automatic stream_frame(input int noise_pct);
        send_pixels(sb.frame_w() * sb.frame_h(), noise_pct);
        send_flushes(sb.frame_w() + 1, noise_pct);
    endtask

    // drop valid, wait for every predicted pixel, then let the pipeline empty
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // output side stall, with an optional long hold-off
    // ------------------------------------------------------------------------
    initial begin : receiver
        forever begin
            @(negedge i_clk);
            if (stall_hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                stall_hold_cycles--;
            end else begin
                i_out_stall <= receiver_stall();
            end
        end
    end

    // sample both channels at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_pixel({o_red_out, o_green_out, o_blue_out, o_alpha_out,
                                o_frame_last});
            if (i_in_valid && !o_in_stall)
                sb.take_request(i_op, {i_alpha_in, i_blue_in, i_green_in, i_red_in});
        end
    end

    // end the run when nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int frame_no;
        int w;
        int h;
        int cut;
        sb = new();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // 3x2 frame with the reset weights, extreme pixels, wrong-kind requests
        pace = PACE_BOTH;
        write_size(CFG_IMAGE_WIDTH, 3);
        write_size(CFG_IMAGE_HEIGHT, 2);
        push_request(1'b0, '0);
        push_request(1'b1, '1);
        push_request(1'b0, '1);
        push_request(1'b0, 32'h8080_8080);
        push_request(1'b0, 32'h0102_0408);
        push_request(1'b0, 32'hFF00_FF00);
        push_request(1'b0, 32'h7F7F_7F7F);
        push_request(1'b0, 32'h5555_AAAA);
        send_flushes(4, 0);
        settle();

        // unmapped register index, then largest weights on a zero-size frame
        write_reg(CFG_UNUSED_IDX, '1);
        write_all_coefs({3{12'h7FF}});
        write_size(CFG_IMAGE_WIDTH, 0);
        write_size(CFG_IMAGE_HEIGHT, 0);
        push_request(1'b0, '1);
        send_flushes(2, 0);
        settle();

        // most negative weights clamp to zero
        write_all_coefs({3{12'h800}});
        push_request(1'b0, '1);
        send_flushes(2, 0);
        settle();

        // oversized width, part of the first line, cut short by a restart
        pace = PACE_FULL;
        write_reg(CFG_COEF_LEFT, rand_coef_reg());
        write_reg(CFG_COEF_MIDDLE, rand_coef_reg());
        write_reg(CFG_COEF_RIGHT, rand_coef_reg());
        write_size(CFG_IMAGE_WIDTH, 2047);
        write_size(CFG_IMAGE_HEIGHT, 2);
        send_pixels(40, 2);
        settle();

        // oversized height on a one-pixel-wide frame, cut short by a restart
        pace = PACE_BOTH;
        write_size(CFG_IMAGE_WIDTH, 1);
        write_size(CFG_IMAGE_HEIGHT, 2047);
        send_pixels(60, 2);
        settle();

        // long output stall while requests keep coming, pipeline fills up
        pace = PACE_FULL;
        write_size(CFG_IMAGE_WIDTH, 8);
        write_size(CFG_IMAGE_HEIGHT, 4);
        stall_hold_cycles = HOLD_OFF;
        stream_frame(0);
        settle();

        // random frames over rotating idle phases
        items_sent = 0;
        frame_no   = 0;
        while (items_sent < RANDOM_ITEMS) begin
            pace = t_pace'(frame_no % 4);
            if (frame_no == 0 || $urandom_range(2) == 0) begin
                settle();
                write_size(CFG_IMAGE_WIDTH, rand_dim(9));
                write_size(CFG_IMAGE_HEIGHT, rand_dim(6));
                if ($urandom_range(1)) write_reg(CFG_COEF_LEFT, rand_coef_reg());
                if ($urandom_range(1)) write_reg(CFG_COEF_MIDDLE, rand_coef_reg());
                if ($urandom_range(1)) write_reg(CFG_COEF_RIGHT, rand_coef_reg());
            end
            w = sb.frame_w();
            h = sb.frame_h();
            case ($urandom_range(7))
                // weights change part-way through the frame
                0: begin
                    cut = $urandom_range(w * h);
                    send_pixels(cut, 5);
                    settle();
                    write_reg(t_cfg_idx'(CFG_COEF_LEFT + $urandom_range(2)),
                              rand_coef_reg());
                    send_pixels(w * h - cut, 5);
                    send_flushes(w + 1, 5);
                end
                // size write part-way restarts the frame
                1: begin
                    send_pixels($urandom_range(w * h), 0);
                    settle();
                    if ($urandom_range(1))
                        write_size(CFG_IMAGE_WIDTH, rand_dim(9));
                    else
                        write_size(CFG_IMAGE_HEIGHT, rand_dim(6));
                end
                // pixels pushed in among the flush requests are dropped; after the last flush they start a new frame
                2: begin
                    cut = $urandom_range(w);
                    send_pixels(w * h, 0);
                    send_flushes(w + 1 - cut, 0);
                    repeat ($urandom_range(3, 1)) push_request(1'b0, rand_pixel());
                    send_flushes(cut, 0);
                end
                3: stream_frame(15);
                default: stream_frame(0);
            endcase
            frame_no++;
        end
        settle();

        if (sb.err_count == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
design/rc3s_pkg.sv
design/rc3s_linebuf.sv
design/rc3s_lane.sv
design/rgba_conv3x3_stream_unit.sv
sim/tb.sv
